### hw/rtl/mcct_pkg.sv
package mcct_pkg;

  // Field widths
  localparam int unsigned STAMP_W   = 16;
  localparam int unsigned IDLE_W    = 16;
  localparam int unsigned SPEED_W   = 24;
  localparam int unsigned RATE_W    = 20;
  localparam int unsigned PPR_W     = 8;
  localparam int unsigned CFG_W     = 20;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned OUT_CH    = 4;
  localparam int unsigned IN_DATA_W = 24;

  // Divider sizing: numerator count_rate*60, denominator period*ppr
  localparam int unsigned PERIOD_W = STAMP_W + 1;
  localparam int unsigned NUM_W    = 26;
  localparam int unsigned DEN_W    = PERIOD_W + PPR_W;
  localparam int unsigned STEP_W   = $clog2(NUM_W);

  localparam int unsigned RPM_SCALE = 60;

  localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};
  localparam logic [IDLE_W-1:0]  IDLE_MAX  = {IDLE_W{1'b1}};

  // Item kinds
  localparam logic CMD_CAPTURE = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PPR        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_LIMIT = 2'd2;

  localparam logic [RATE_W-1:0]  COUNT_RATE_RST = 20'd10000;
  localparam logic [PPR_W-1:0]   PPR_RST        = 8'd5;
  localparam logic [IDLE_W-1:0]  STOP_LIMIT_RST = 16'd20;

  typedef struct packed {
    logic [IDLE_W-1:0]  idle;
    logic [STAMP_W-1:0] stamp;
  } chan_entry_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [SPEED_W-1:0] quot;
  } div_rsp_t;

endpackage

### hw/rtl/mcct_div.sv
module mcct_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mcct_pkg::div_req_t req_i,
  output mcct_pkg::div_rsp_t rsp_o
);
  import mcct_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              zero_q, zero_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [DEN_W:0]    trial;
  logic              fits;

  // Restoring division, one quotient bit per cycle
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    zero_d = zero_q;
    step_d = step_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      zero_d = (req_i.den == '0);
      step_d = '0;
      rem_d  = '0;
      den_d  = req_i.den;
      quo_d  = req_i.num;
    end else if (busy_q) begin
      rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], fits};
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= zero_d;
    step_q <= step_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    quo_q  <= quo_d;
  end

  // Saturate on a zero divisor or a quotient beyond the speed range
  assign rsp_o.done = done_q;
  assign rsp_o.quot = (zero_q || (|quo_q[NUM_W-1:SPEED_W])) ? SPEED_MAX
                                                              : quo_q[SPEED_W-1:0];

endmodule

### hw/rtl/mcct_chan_mem.sv
module mcct_chan_mem #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned AW    = 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   re_i,
  input  logic [AW-1:0]          raddr_i,
  input  logic                   we_i,
  input  logic [AW-1:0]          waddr_i,
  input  mcct_pkg::chan_entry_t  wdata_i,
  output mcct_pkg::chan_entry_t  rdata_o
);
  import mcct_pkg::*;

  chan_entry_t            mem_q [DEPTH];
  logic [DEPTH-1:0]       valid_q;
  chan_entry_t            rd_q;
  logic                   rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // An entry never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  // Forward a write to the same entry
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_q <= (we_i && waddr_i == raddr_i) ? wdata_i : mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else if (re_i) begin
      rd_valid_q <= valid_q[raddr_i] || (we_i && waddr_i == raddr_i);
    end
  end

  assign rdata_o = rd_valid_q ? rd_q : '0;

endmodule

### hw/rtl/multi_channel_capture_tachometer.sv
// Capture item: one channel-memory read, then the 26-step serial divider, then the result
//   is registered for output once the output register is free.
// Tick item: every entry is read and written back in turn, one entry per cycle.
// One item at a time; the next item is accepted while the result waits in the output register.
// Reset (async, active low): registers return to their defaults, speeds clear, and the
//   per-entry valid bits clear so every stamp and idle count reads as zero; no clearing pass.
module multi_channel_capture_tachometer #(
  parameter int unsigned CHANNELS = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Capture / tick items
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [mcct_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // channel[1:0], capture_value[17:2]
  input  logic                               s_axis_tuser,  // cmd[0]
  // Speed results
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [mcct_pkg::OUT_CH*mcct_pkg::SPEED_W-1:0] m_axis_tdata,
                                             // speed_ch0, speed_ch1, speed_ch2, speed_ch3
  // Configuration writes
  input  logic                               cfg_we_i,
  input  logic [mcct_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mcct_pkg::CFG_W-1:0]         cfg_wdata_i
);
  import mcct_pkg::*;

  localparam int unsigned CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_AW-1:0] LAST_CH = CH_AW'(CHANNELS - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CAP  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_TICK = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  // Configuration registers
  logic [RATE_W-1:0] count_rate_q;
  logic [PPR_W-1:0]  ppr_q;
  logic [IDLE_W-1:0] stop_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_rate_q <= COUNT_RATE_RST;
      ppr_q        <= PPR_RST;
      stop_limit_q <= STOP_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_COUNT_RATE: count_rate_q <= cfg_wdata_i[RATE_W-1:0];
        REG_PPR:        ppr_q        <= cfg_wdata_i[PPR_W-1:0];
        REG_STOP_LIMIT: stop_limit_q <= cfg_wdata_i[IDLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state
  logic [2:0]          state_q, state_d;
  logic [CH_AW-1:0]    chan_q, chan_d;
  logic [CH_AW-1:0]    idx_q, idx_d;
  logic [STAMP_W-1:0]  stamp_q, stamp_d;
  logic [SPEED_W-1:0]  speed_q [CHANNELS];
  logic [SPEED_W-1:0]  speed_d [CHANNELS];
  logic                m_valid_q, m_valid_d;
  logic [OUT_CH*SPEED_W-1:0] m_data_q, m_data_d;
  logic [SPEED_W-1:0]  speed_out [OUT_CH];

  // Channel memory and divider hookup
  logic             mem_re, mem_we;
  logic [CH_AW-1:0] mem_raddr, mem_waddr;
  chan_entry_t      mem_wdata, mem_rdata;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  // Input item fields
  logic [1:0]          in_chan;
  logic [STAMP_W-1:0]  in_stamp;
  logic                in_cmd;
  logic                in_accept;
  logic                in_present;

  // Period and idle-count arithmetic
  logic [STAMP_W-1:0]  diff;
  logic [PERIOD_W-1:0] period;
  logic [IDLE_W-1:0]   idle_inc;
  logic                idle_expire;
  logic [IDLE_W-1:0]   idle_nx;

  assign in_chan    = s_axis_tdata[1:0];
  assign in_stamp   = s_axis_tdata[2 +: STAMP_W];
  assign in_cmd     = s_axis_tuser;
  assign in_accept  = s_axis_tvalid && s_axis_tready;
  assign in_present = 32'(in_chan) < CHANNELS;

  // Equal stamps mean a full counter wrap
  assign diff   = stamp_q - mem_rdata.stamp;
  assign period = (diff == '0) ? {1'b1, {STAMP_W{1'b0}}} : {1'b0, diff};

  // Saturate the idle count, then drop the speed once the limit is met
  assign idle_inc    = (mem_rdata.idle != IDLE_MAX) ? mem_rdata.idle + 1'b1 : mem_rdata.idle;
  assign idle_expire = idle_inc >= stop_limit_q;
  assign idle_nx     = idle_expire ? '0 : idle_inc;

  // Channels beyond CHANNELS report zero
  for (genvar j = 0; j < OUT_CH; j++) begin : g_out
    if (j < CHANNELS) begin : g_real
      assign speed_out[j] = speed_q[j];
    end else begin : g_none
      assign speed_out[j] = '0;
    end
  end

  always_comb begin
    state_d   = state_q;
    chan_d    = chan_q;
    idx_d     = idx_q;
    stamp_d   = stamp_q;
    speed_d   = speed_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;

    mem_re    = 1'b0;
    mem_raddr = CH_AW'(in_chan);
    mem_we    = 1'b0;
    mem_waddr = chan_q;
    mem_wdata = '0;

    div_req.start = 1'b0;
    div_req.num   = NUM_W'(count_rate_q) * NUM_W'(RPM_SCALE);
    div_req.den   = DEN_W'(period) * DEN_W'(ppr_q);

    // Drop the result once it is taken
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_cmd == CMD_TICK) begin
            mem_re    = 1'b1;
            mem_raddr = '0;
            idx_d     = '0;
            state_d   = ST_TICK;
          end else if (in_present) begin
            mem_re  = 1'b1;
            chan_d  = CH_AW'(in_chan);
            stamp_d = in_stamp;
            state_d = ST_CAP;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_CAP: begin
        // Store the new stamp, clear the idle count, launch the divide
        mem_we          = 1'b1;
        mem_waddr       = chan_q;
        mem_wdata.stamp = stamp_q;
        mem_wdata.idle  = '0;
        div_req.start   = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          speed_d[chan_q] = div_rsp.quot;
          state_d         = ST_FIN;
        end
      end
      ST_TICK: begin
        // Write back entry idx_q while entry idx_q+1 is read
        mem_we          = 1'b1;
        mem_waddr       = idx_q;
        mem_wdata.stamp = mem_rdata.stamp;
        mem_wdata.idle  = idle_nx;
        if (idle_expire) begin
          speed_d[idx_q] = '0;
        end
        if (idx_q == LAST_CH) begin
          state_d = ST_FIN;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_q + 1'b1;
          idx_d     = idx_q + 1'b1;
        end
      end
      ST_FIN: begin
        // Hold until the output register is free
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          for (int k = 0; k < OUT_CH; k++) begin
            m_data_d[k*SPEED_W +: SPEED_W] = speed_out[k];
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      for (int k = 0; k < CHANNELS; k++) begin
        speed_q[k] <= '0;
      end
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      speed_q   <= speed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chan_q   <= chan_d;
    idx_q    <= idx_d;
    stamp_q  <= stamp_d;
    m_data_q <= m_data_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  mcct_chan_mem #(
    .DEPTH (CHANNELS),
    .AW    (CH_AW)
  ) u_chan_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  mcct_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide wait");

  a_write_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CAP || state_q == ST_TICK))
    else $error("channel memory written while no item is in work");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == ST_FIN)
    else $error("result shown without finishing an item");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> state_q != ST_IDLE)
    else $error("accepted item did not start work");

endmodule

### verif/mcct_checker.sv
`timescale 1ns / 100ps

// Watches the item, result and configuration channels of the tachometer,
// keeps its own copy of the channel state and registers, and compares every
// result against the oldest predicted speed set.
module mcct_checker
  import mcct_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  input  logic [IN_DATA_W-1:0]        s_axis_tdata,
  input  logic                        s_axis_tuser,
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic [OUT_CH*SPEED_W-1:0]   m_axis_tdata,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_W-1:0]            cfg_wdata_i,
  output int                          fail_count_o,
  output int                          pending_o
);

  localparam int unsigned NUM_CH = 4;
  localparam int unsigned REPORT_MAX = 10;

  logic [RATE_W-1:0]  rate_cfg;
  logic [PPR_W-1:0]   ppr_cfg;
  logic [IDLE_W-1:0]  stop_cfg;

  logic [STAMP_W-1:0] stamp_mem [NUM_CH];
  logic [SPEED_W-1:0] rpm_mem   [NUM_CH];
  logic [IDLE_W-1:0]  idle_mem  [NUM_CH];

  logic [OUT_CH*SPEED_W-1:0] speed_expect_q [$];

  function automatic logic [SPEED_W-1:0] rpm_of_period(logic [PERIOD_W-1:0] period);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    num = 64'(rate_cfg) * 64'(RPM_SCALE);
    den = 64'(period) * 64'(ppr_cfg);
    if (den == 64'd0) return SPEED_MAX;
    quo = num / den;
    if (quo > 64'(SPEED_MAX)) return SPEED_MAX;
    return quo[SPEED_W-1:0];
  endfunction

  task automatic take_capture(logic [1:0] ch, logic [STAMP_W-1:0] stamp);
    logic [PERIOD_W-1:0] period;
    period = {1'b0, stamp - stamp_mem[ch]};
    if (period == '0) period = PERIOD_W'(1) << STAMP_W;
    rpm_mem[ch]   = rpm_of_period(period);
    stamp_mem[ch] = stamp;
    idle_mem[ch]  = '0;
  endtask

  task automatic take_tick();
    logic [IDLE_W-1:0] cnt;
    for (int i = 0; i < NUM_CH; i++) begin
      cnt = idle_mem[i];
      if (cnt < IDLE_MAX) cnt = cnt + 1'b1;
      if (cnt >= stop_cfg) begin
        rpm_mem[i] = '0;
        cnt = '0;
      end
      idle_mem[i] = cnt;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [OUT_CH*SPEED_W-1:0] want;
    logic [OUT_CH*SPEED_W-1:0] snap;
    if (!rst_ni) begin
      rate_cfg = COUNT_RATE_RST;
      ppr_cfg  = PPR_RST;
      stop_cfg = STOP_LIMIT_RST;
      for (int i = 0; i < NUM_CH; i++) begin
        stamp_mem[i] = '0;
        rpm_mem[i]   = '0;
        idle_mem[i]  = '0;
      end
      speed_expect_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_COUNT_RATE: rate_cfg = cfg_wdata_i[RATE_W-1:0];
          REG_PPR:        ppr_cfg  = cfg_wdata_i[PPR_W-1:0];
          REG_STOP_LIMIT: stop_cfg = cfg_wdata_i[IDLE_W-1:0];
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == CMD_TICK) take_tick();
        else take_capture(s_axis_tdata[1:0], s_axis_tdata[STAMP_W+1:2]);
        for (int j = 0; j < OUT_CH; j++)
          snap[j*SPEED_W +: SPEED_W] = (j < NUM_CH) ? rpm_mem[j] : '0;
        speed_expect_q.push_back(snap);
      end

      if (m_axis_tvalid && m_axis_tready) begin
        if (speed_expect_q.size() == 0) begin
          if (fail_count_o < REPORT_MAX)
            $display("%0t: unexpected result %h", $realtime, m_axis_tdata);
          fail_count_o++;
        end else begin
          want = speed_expect_q.pop_front();
          for (int j = 0; j < OUT_CH; j++) begin
            if (m_axis_tdata[j*SPEED_W +: SPEED_W] !== want[j*SPEED_W +: SPEED_W]) begin
              if (fail_count_o < REPORT_MAX)
                $display("%0t: speed_ch%0d expected %0d got %0d", $realtime, j,
                         want[j*SPEED_W +: SPEED_W], m_axis_tdata[j*SPEED_W +: SPEED_W]);
              fail_count_o++;
            end
          end
        end
      end
      pending_o = speed_expect_q.size();
    end
  end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the tachometer; checking lives in mcct_checker.
module tb_top;
  import mcct_pkg::*;

  localparam int unsigned WATCHDOG_CYCLES = 4000;  // cycles with no item moving
  localparam int unsigned DRAIN_CYCLES    = 40;    // margin after the last expected result
  localparam int unsigned SQUEEZE_CYCLES  = 600;   // long receiver hold-off
  localparam int unsigned PHASES          = 10;
  localparam int unsigned PHASE_ITEMS     = 115;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        s_axis_tvalid;
  logic                        s_axis_tready;
  logic [IN_DATA_W-1:0]        s_axis_tdata;
  logic                        s_axis_tuser;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready;
  logic [OUT_CH*SPEED_W-1:0]   m_axis_tdata;
  logic                        cfg_we_i;
  logic [CFG_IDX_W-1:0]        cfg_index_i;
  logic [CFG_W-1:0]            cfg_wdata_i;

  int   fail_count;
  int   pending;
  logic item_taken = 1'b0;   // an item was accepted at the last rising edge
  bit   squeeze_req = 1'b0;  // ask the receiver for one long hold-off
  int   quiet_cycles = 0;

  logic [STAMP_W-1:0] stamp_gen [4];  // running timestamp per channel

  multi_channel_capture_tachometer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  mcct_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Sample the input handshake at the edge; the sender reads it at the next falling edge.
  always @(posedge clk_i) item_taken <= s_axis_tvalid && s_axis_tready;

  // Watchdog: end the run when no item moves on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random ready pattern, mostly open, with short and rare long stalls.
  // One assignment of tready per falling edge.
  initial begin : receiver
    int pick;
    int len;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (squeeze_req) begin
        // Hold off long enough that the block fills and stalls its input.
        m_axis_tready <= 1'b0;
        repeat (SQUEEZE_CYCLES - 1) @(negedge clk_i);
        squeeze_req = 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          m_axis_tready <= 1'b1;
          len = $urandom_range(1, 30);
        end else if (pick < 85) begin
          m_axis_tready <= 1'b0;
          len = $urandom_range(1, 3);
        end else if (pick < 95) begin
          m_axis_tready <= 1'b0;
          len = $urandom_range(4, 12);
        end else begin
          m_axis_tready <= 1'b0;
          len = $urandom_range(20, 60);
        end
        repeat (len - 1) @(negedge clk_i);
      end
    end
  end

  // Offer one item after a gap and hold it until accepted. Call at a falling edge;
  // returns at the falling edge right after the accepting rising edge, tvalid still high.
  task automatic send_item(logic cmd, logic [1:0] ch, logic [STAMP_W-1:0] val, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {{(IN_DATA_W-STAMP_W-2){1'b0}}, val, ch};
    @(negedge clk_i);
    while (!item_taken) @(negedge clk_i);
  endtask

  // Drop tvalid and wait until every expected result has arrived, plus a margin.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
  endtask

  // Reprogram all three registers while the block is idle.
  task automatic set_config(logic [RATE_W-1:0] rate, logic [PPR_W-1:0] ppr,
                            logic [IDLE_W-1:0] stop);
    drain();
    cfg_write(REG_COUNT_RATE, CFG_W'(rate));
    cfg_write(REG_PPR, CFG_W'(ppr));
    cfg_write(REG_STOP_LIMIT, CFG_W'(stop));
    cfg_we_i <= 1'b0;
  endtask

  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  initial begin : stimulus
    int r;
    int gap;
    bit burst;
    logic [1:0] ch;
    logic [STAMP_W-1:0] val;
    logic [RATE_W-1:0] rate;
    logic [PPR_W-1:0] ppr;
    logic [IDLE_W-1:0] stop;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_CAPTURE;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_COUNT_RATE;
    cfg_wdata_i   = '0;
    for (int i = 0; i < 4; i++) stamp_gen[i] = '0;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part with reset register values.
    // First capture: measured from a stored stamp of 0, equal stamp gives full range.
    send_item(CMD_CAPTURE, 2'd0, 16'h0000, 0);
    send_item(CMD_CAPTURE, 2'd1, 16'hFFFF, 1);
    // Same stamp again: full-range period.
    send_item(CMD_CAPTURE, 2'd1, 16'hFFFF, 0);
    // Shortest period.
    send_item(CMD_CAPTURE, 2'd2, 16'h0001, 0);
    send_item(CMD_CAPTURE, 2'd2, 16'h0002, 2);
    // Counter wrap between captures.
    send_item(CMD_CAPTURE, 2'd3, 16'h8000, 0);
    send_item(CMD_CAPTURE, 2'd3, 16'h0000, 0);
    // Ticks: channel and value are don't-care, drive both extremes.
    send_item(CMD_TICK, 2'd3, 16'hFFFF, 0);
    send_item(CMD_TICK, 2'd0, 16'h0000, 1);

    // High rate, one pulse per rev: the shortest period saturates; one tick stops everything.
    set_config(20'd1000000, 8'd1, 16'd1);
    send_item(CMD_CAPTURE, 2'd0, 16'h000A, 0);
    send_item(CMD_CAPTURE, 2'd0, 16'h000B, 0);
    send_item(CMD_CAPTURE, 2'd2, 16'h5555, 0);
    send_item(CMD_TICK, 2'd1, 16'hAAAA, 0);

    // Zero pulses per revolution: divisor of zero saturates.
    set_config(20'hFFFFF, 8'd0, 16'hFFFF);
    send_item(CMD_CAPTURE, 2'd1, 16'h1234, 0);
    send_item(CMD_CAPTURE, 2'd3, 16'hFFFF, 0);

    // Zero count rate: speed reads 0.
    set_config(20'd0, 8'hFF, 16'd20);
    send_item(CMD_CAPTURE, 2'd2, 16'h00FF, 0);
    send_item(CMD_CAPTURE, 2'd0, 16'hFF00, 0);

    // Zero stop limit: every tick clears all speeds.
    set_config(20'd10000, 8'd5, 16'd0);
    send_item(CMD_CAPTURE, 2'd0, 16'h0100, 0);
    send_item(CMD_CAPTURE, 2'd1, 16'h0010, 0);
    send_item(CMD_TICK, 2'd2, 16'h0F0F, 0);
    send_item(CMD_TICK, 2'd1, 16'hF0F0, 0);

    // Random part, phase by phase through several register settings.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin rate = 20'd10000;   ppr = 8'd5;   stop = 16'd20;    end
        1: begin rate = 20'd1000000; ppr = 8'd1;   stop = 16'd3;     end
        2: begin rate = 20'hFFFFF;   ppr = 8'd255; stop = 16'hFFFF;  end
        3: begin rate = 20'd1;       ppr = 8'd255; stop = 16'd1;     end
        4: begin rate = 20'd0;       ppr = 8'd7;   stop = 16'd5;     end
        5: begin rate = 20'd50000;   ppr = 8'd0;   stop = 16'd0;     end
        default: begin
          rate = RATE_W'($urandom_range(1, 1000000));
          ppr  = PPR_W'($urandom_range(1, 255));
          stop = IDLE_W'($urandom_range(1, 40));
        end
      endcase
      set_config(rate, ppr, stop);
      burst = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Squeeze the output once while the sender keeps offering items.
        if (phase == 2 && n == 10) squeeze_req = 1'b1;
        gap = pick_gap(burst);
        r = $urandom_range(0, 99);
        ch = 2'($urandom_range(0, 3));
        if (r < 20) begin
          send_item(CMD_TICK, ch, STAMP_W'($urandom_range(0, 65535)), gap);
        end else if (r < 30) begin
          // Noise: capture at an arbitrary stamp.
          val = STAMP_W'($urandom_range(0, 65535));
          stamp_gen[ch] = val;
          send_item(CMD_CAPTURE, ch, val, gap);
        end else begin
          // Steady rotation: advance the channel's stamp by a plausible period.
          r = $urandom_range(0, 99);
          if (r < 50)      val = STAMP_W'($urandom_range(1, 64));
          else if (r < 80) val = STAMP_W'($urandom_range(65, 4095));
          else             val = STAMP_W'($urandom_range(0, 65535));
          stamp_gen[ch] = stamp_gen[ch] + val;
          send_item(CMD_CAPTURE, ch, stamp_gen[ch], gap);
        end
      end
    end

    drain();
    if (fail_count == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
